// ----- src/wam_pkg.sv -----
// wam_pkg: shared constants and codes for the weighted adjacency matrix block
// no dependencies
`default_nettype none

package wam_pkg;

	// table geometry
	localparam int MAX_VERTICES = 8;
	localparam int WEIGHT_BITS  = 16;
	localparam int TABLE_SIZE   = MAX_VERTICES * MAX_VERTICES;
	localparam int ADDR_W       = $clog2(TABLE_SIZE);
	localparam int ROW_W        = $clog2(MAX_VERTICES);

	// field widths
	localparam int VTX_W    = 8;
	localparam int IN_W_W   = 16;
	localparam int OUT_W_W  = 16;
	localparam int NB_W     = 4;
	localparam int STAT_W   = 2;
	localparam int COUNT_W  = 4;
	localparam int EDGE_W   = 6;
	localparam int CFG_W    = 6;
	localparam int CFG_IDX_W = 1;

	// opcodes
	localparam logic OP_LIST   = 1'b0;
	localparam logic OP_MODIFY = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] STAT_NEIGHBOR = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_INVALID  = 2'd2;

	// register indexes, reset values and the edge total limit
	localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_EDGES    = 1'd1;
	localparam logic [COUNT_W-1:0]   VERTEX_COUNT_RST = 4'd6;
	localparam logic [EDGE_W-1:0]    MAX_EDGES_RST    = 6'd21;
	localparam logic [EDGE_W-1:0]    EDGE_TOTAL_MAX   = 6'd63;

	// saturation limits for stored weights
	localparam longint W_HI_L = (longint'(1) << (WEIGHT_BITS - 1)) - 1;
	localparam logic signed [32:0] W_HI = 33'(W_HI_L);
	localparam logic signed [32:0] W_LO = 33'(-W_HI_L - 1);

endpackage

`default_nettype wire

// ----- src/weighted_adjacency_matrix.sv -----
// weighted_adjacency_matrix: symmetric weight table with edge counter, list and modify
// depends on wam_pkg
// list: busy through the scan of the n active vertices, a drain and a finish state, one table read per cycle
// from the weight memory's read port; results come as neighbors are found, last one after the scan
// modify: busy through states RD_A, RD_B, CHECK and WR_B (two reads, then up to two writes), no result
// invalid vertex: not busy, the status result appears the cycle after acceptance
// reset clears the table at once through per-entry valid bits, edge count to zero,
// registers to their defaults; results cannot be stalled by the receiver
`default_nettype none

module weighted_adjacency_matrix import wam_pkg::*; (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic                        opcode,
	input  wire logic [VTX_W-1:0]            src_vertex,
	input  wire logic [VTX_W-1:0]            dst_vertex,
	input  wire logic signed [IN_W_W-1:0]    edge_weight,
	output logic                             result_strobe,
	output logic [STAT_W-1:0]                status,
	output logic [NB_W-1:0]                  neighbor,
	output logic signed [OUT_W_W-1:0]        neighbor_weight,
	output logic                             last,
	input  wire logic                        cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]            cfg_wdata
);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DRAIN  = 3'd2;
	localparam logic [2:0] ST_FINISH = 3'd3;
	localparam logic [2:0] ST_RD_A   = 3'd4;
	localparam logic [2:0] ST_RD_B   = 3'd5;
	localparam logic [2:0] ST_CHECK  = 3'd6;
	localparam logic [2:0] ST_WR_B   = 3'd7;

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [ROW_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(MAX_VERTICES) + ADDR_W'(c);
	endfunction

	function automatic logic vertex_ok(input logic [VTX_W-1:0] v, input logic [VTX_W-1:0] act);
		return (v != '0) && (v <= act);
	endfunction

	function automatic logic signed [WEIGHT_BITS-1:0] sat_weight(
		input logic signed [IN_W_W-1:0] w);
		logic signed [32:0] wx;
		wx = 33'(w);
		if (wx > W_HI) return WEIGHT_BITS'(W_HI);
		if (wx < W_LO) return WEIGHT_BITS'(W_LO);
		return WEIGHT_BITS'(wx);
	endfunction

	function automatic logic [OUT_W_W-1:0] out_weight(input logic signed [WEIGHT_BITS-1:0] w);
		logic signed [31:0] t;
		t = 32'(w);
		return t[OUT_W_W-1:0];
	endfunction

	function automatic logic [NB_W-1:0] col_to_nb(input logic [ROW_W-1:0] c);
		logic [VTX_W-1:0] i;
		i = VTX_W'(c) + VTX_W'(1);
		return i[NB_W-1:0];
	endfunction

	logic [2:0]                    state_q;
	logic [COUNT_W-1:0]            vertex_count_q;
	logic [EDGE_W-1:0]             max_edges_q;
	logic [EDGE_W-1:0]             edge_total_q;
	logic [ROW_W-1:0]              row_q;
	logic [ROW_W-1:0]              col_q;
	logic signed [WEIGHT_BITS-1:0] wt_q;
	logic                          a_nz_q;
	logic                          wr_q;
	logic                          pend_q;
	logic [NB_W-1:0]               pend_nb_q;
	logic signed [WEIGHT_BITS-1:0] pend_w_q;

	// weight memory and per-entry valid bits
	logic signed [WEIGHT_BITS-1:0] mem [TABLE_SIZE];
	logic [TABLE_SIZE-1:0]         valid_q;
	logic signed [WEIGHT_BITS-1:0] rd_data_s1;
	logic                          rd_ok_s1;
	logic                          live_s1;
	logic [ROW_W-1:0]              col_s1;

	logic [VTX_W-1:0]              active;
	logic [ROW_W-1:0]              last_col;
	logic                          accept;
	logic                          in_ok;
	logic [ADDR_W-1:0]             rd_addr;
	logic                          mem_we;
	logic [ADDR_W-1:0]             wr_addr;
	logic signed [WEIGHT_BITS-1:0] rd_val;
	logic                          found;
	logic                          exists;
	logic                          do_del;
	logic                          do_add;
	logic                          do_wr;

	logic                          emit;
	logic [STAT_W-1:0]             e_status;
	logic [NB_W-1:0]               e_nb;
	logic signed [WEIGHT_BITS-1:0] e_w;
	logic                          e_last;

	// active vertex count, clipped to the table
	always_comb begin
		if (VTX_W'(vertex_count_q) > VTX_W'(MAX_VERTICES)) begin
			active = VTX_W'(MAX_VERTICES);
		end else begin
			active = VTX_W'(vertex_count_q);
		end
	end

	assign last_col = ROW_W'(active - VTX_W'(1));
	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign in_ok    = vertex_ok(src_vertex, active)
		&& ((opcode == OP_LIST) || vertex_ok(dst_vertex, active));
	assign rd_val   = rd_ok_s1 ? rd_data_s1 : '0;
	assign found    = live_s1 && (rd_val != '0);

	// modify decision, taken when the mirror entry arrives
	assign exists = a_nz_q && (rd_val != '0);
	assign do_del = exists && (wt_q == '0) && (edge_total_q != '0);
	assign do_add = !exists && (wt_q != '0) && (edge_total_q < max_edges_q)
		&& (edge_total_q < EDGE_TOTAL_MAX);
	assign do_wr  = do_add || (exists && ((wt_q != '0) || do_del));

	// memory address selection
	always_comb begin
		rd_addr = cell_addr(row_q, col_q);
		wr_addr = cell_addr(row_q, col_q);
		mem_we  = 1'b0;
		case (state_q)
			ST_RD_B: begin
				rd_addr = cell_addr(col_q, row_q);
			end
			ST_CHECK: begin
				mem_we = do_wr;
			end
			ST_WR_B: begin
				wr_addr = cell_addr(col_q, row_q);
				mem_we  = wr_q;
			end
			default: begin
			end
		endcase
	end

	// weight memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wt_q;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_ok_s1 <= 1'b0;
		end else begin
			if (mem_we) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_ok_s1 <= valid_q[rd_addr];
		end
	end

	// result selection
	always_comb begin
		emit     = 1'b0;
		e_status = STAT_NEIGHBOR;
		e_nb     = '0;
		e_w      = '0;
		e_last   = 1'b0;
		if (accept && !in_ok) begin
			emit     = 1'b1;
			e_status = STAT_INVALID;
			e_last   = 1'b1;
		end else if (state_q == ST_FINISH) begin
			emit = 1'b1;
			e_last = 1'b1;
			if (pend_q) begin
				e_nb = pend_nb_q;
				e_w  = pend_w_q;
			end else begin
				e_status = STAT_EMPTY;
			end
		end else if (found && pend_q) begin
			emit = 1'b1;
			e_nb = pend_nb_q;
			e_w  = pend_w_q;
		end
	end

	// output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status          <= e_status;
			neighbor        <= e_nb;
			neighbor_weight <= out_weight(e_w);
			last            <= e_last;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= VERTEX_COUNT_RST;
			max_edges_q    <= MAX_EDGES_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_VERTEX_COUNT: vertex_count_q <= cfg_wdata[COUNT_W-1:0];
				REG_MAX_EDGES:    max_edges_q    <= cfg_wdata[EDGE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			edge_total_q <= '0;
			pend_q       <= 1'b0;
			live_s1      <= 1'b0;
			wr_q         <= 1'b0;
		end else begin
			live_s1 <= (state_q == ST_SCAN);
			if (found) begin
				pend_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && in_ok) begin
						pend_q <= 1'b0;
						if (opcode == OP_LIST) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_RD_A;
						end
					end
				end
				ST_SCAN: begin
					if (col_q == last_col) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				ST_RD_A: begin
					state_q <= ST_RD_B;
				end
				ST_RD_B: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					wr_q <= do_wr;
					if (do_add) begin
						edge_total_q <= edge_total_q + EDGE_W'(1);
					end else if (do_del) begin
						edge_total_q <= edge_total_q - EDGE_W'(1);
					end
					state_q <= ST_WR_B;
				end
				ST_WR_B: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item registers and scan column
	always_ff @(posedge clk) begin
		col_s1 <= col_q;
		if (found) begin
			pend_nb_q <= col_to_nb(col_s1);
			pend_w_q  <= rd_val;
		end
		case (state_q)
			ST_IDLE: begin
				row_q <= ROW_W'(src_vertex - VTX_W'(1));
				if (opcode == OP_LIST) begin
					col_q <= '0;
				end else begin
					col_q <= ROW_W'(dst_vertex - VTX_W'(1));
				end
				wt_q <= sat_weight(edge_weight);
			end
			ST_SCAN: begin
				if (col_q != last_col) begin
					col_q <= col_q + ROW_W'(1);
				end
			end
			ST_RD_B: begin
				a_nz_q <= (rd_val != '0);
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- sim/weighted_adjacency_matrix_tb.sv -----
// weighted_adjacency_matrix_tb: self-checking bench for the weighted adjacency matrix block
// drives list and modify transactions, predicts every result from a shadow weight table
// depends on wam_pkg and weighted_adjacency_matrix
`default_nettype none

module weighted_adjacency_matrix_tb;
	import wam_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_PER_SETTING = 29;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [NB_W-1:0]    nb;
		logic [OUT_W_W-1:0] weight;
		logic               is_last;
	} graph_result_t;

	// block ports
	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic                     opcode = OP_LIST;
	logic [VTX_W-1:0]         src_vertex = '0;
	logic [VTX_W-1:0]         dst_vertex = '0;
	logic signed [IN_W_W-1:0] edge_weight = '0;
	logic                     result_strobe;
	logic [STAT_W-1:0]        status;
	logic [NB_W-1:0]          neighbor;
	logic signed [OUT_W_W-1:0] neighbor_weight;
	logic                     last;
	logic                     cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_VERTEX_COUNT;
	logic [CFG_W-1:0]         cfg_wdata = '0;

	// shadow copy of the graph and its registers
	logic signed [WEIGHT_BITS-1:0] shadow_weights [TABLE_SIZE];
	logic [EDGE_W-1:0]             shadow_edges = '0;
	logic [COUNT_W-1:0]            shadow_vcount = VERTEX_COUNT_RST;
	logic [EDGE_W-1:0]             shadow_max_edges = MAX_EDGES_RST;

	graph_result_t pending_results [$];

	int gap_pct = 20;
	int n_lists = 0;
	int n_modifies = 0;
	int n_results = 0;
	int n_settings = 0;
	int n_errors = 0;
	int cycle_count = 0;

	weighted_adjacency_matrix u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.opcode          (opcode),
		.src_vertex      (src_vertex),
		.dst_vertex      (dst_vertex),
		.edge_weight     (edge_weight),
		.result_strobe   (result_strobe),
		.status          (status),
		.neighbor        (neighbor),
		.neighbor_weight (neighbor_weight),
		.last            (last),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
				cycle_count, pending_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int cell_of(int r, int c);
		return (r - 1) * MAX_VERTICES + (c - 1);
	endfunction

	function automatic logic vertex_in_range(logic [VTX_W-1:0] v, int n);
		return (v >= 1) && (int'(v) <= n);
	endfunction

	function automatic int active_vertices();
		return (shadow_vcount > MAX_VERTICES) ? MAX_VERTICES : int'(shadow_vcount);
	endfunction

	// work out the results of one accepted transaction and update the shadow graph
	task automatic apply_graph_op(input logic op, input logic [VTX_W-1:0] s,
			input logic [VTX_W-1:0] d, input logic signed [IN_W_W-1:0] w);
		int n, hits, k, a, b;
		logic exists;
		logic signed [WEIGHT_BITS-1:0] v;
		n = active_vertices();
		if (op == OP_LIST) begin
			n_lists++;
			if (!vertex_in_range(s, n)) begin
				pending_results.push_back({STAT_INVALID, NB_W'(0), OUT_W_W'(0), 1'b1});
			end else begin
				hits = 0;
				for (k = 1; k <= n; k++) begin
					if (shadow_weights[cell_of(s, k)] != 0)
						hits++;
				end
				if (hits == 0) begin
					pending_results.push_back({STAT_EMPTY, NB_W'(0), OUT_W_W'(0), 1'b1});
				end else begin
					// ascending neighbor order, last flag on the final one
					for (k = 1; k <= n; k++) begin
						v = shadow_weights[cell_of(s, k)];
						if (v != 0) begin
							hits--;
							pending_results.push_back({STAT_NEIGHBOR, NB_W'(k), v, hits == 0});
						end
					end
				end
			end
		end else begin
			n_modifies++;
			if (!vertex_in_range(s, n) || !vertex_in_range(d, n)) begin
				pending_results.push_back({STAT_INVALID, NB_W'(0), OUT_W_W'(0), 1'b1});
			end else begin
				// weight field is as wide as the table, so saturation never changes it
				a = cell_of(s, d);
				b = cell_of(d, s);
				exists = (shadow_weights[a] != 0) && (shadow_weights[b] != 0);
				if (exists && w == 0) begin
					if (shadow_edges != 0) begin
						shadow_weights[a] = '0;
						shadow_weights[b] = '0;
						shadow_edges--;
					end
				end else if (!exists && w != 0) begin
					if (shadow_edges < shadow_max_edges && shadow_edges < EDGE_TOTAL_MAX) begin
						shadow_weights[a] = w;
						shadow_weights[b] = w;
						shadow_edges++;
					end
				end else if (exists) begin
					shadow_weights[a] = w;
					shadow_weights[b] = w;
				end
			end
		end
	endtask

	// one transaction; start is left high so back-to-back items need no extra edge
	task automatic send_item(input logic op, input logic [VTX_W-1:0] s,
			input logic [VTX_W-1:0] d, input logic signed [IN_W_W-1:0] w);
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct)
				@(posedge clk);
		end
		start <= 1'b1;
		opcode <= op;
		src_vertex <= s;
		dst_vertex <= d;
		edge_weight <= w;
		do
			@(posedge clk);
		while (busy);
		apply_graph_op(op, s, d, w);
	endtask

	// drop start and let every outstanding result drain
	task automatic wait_quiet();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers while the block is idle
	task automatic set_config(input logic [CFG_W-1:0] vcount, input logic [CFG_W-1:0] max_e);
		wait_quiet();
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_VERTEX_COUNT;
		cfg_wdata <= vcount;
		@(posedge clk);
		shadow_vcount = vcount[COUNT_W-1:0];
		cfg_index <= REG_MAX_EDGES;
		cfg_wdata <= max_e;
		@(posedge clk);
		shadow_max_edges = max_e[EDGE_W-1:0];
		cfg_wr_en <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [VTX_W-1:0] pick_vertex();
		int r, n;
		r = $urandom_range(99);
		n = active_vertices();
		if (r < 6)
			return '0;
		if (r < 12 || n == 0)
			return VTX_W'($urandom_range(255));
		return VTX_W'($urandom_range(n, 1));
	endfunction

	task automatic send_random_item();
		logic signed [IN_W_W-1:0] w;
		int r;
		r = $urandom_range(99);
		if (r < 25)
			w = '0;
		else if (r < 32)
			w = 16'sh7FFF;
		else if (r < 39)
			w = 16'sh8000;
		else if (r < 44)
			w = -16'sd1;
		else
			w = IN_W_W'($urandom);
		send_item(1'($urandom_range(1)), pick_vertex(), pick_vertex(), w);
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			n_errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	// result checker: every strobed result against the oldest expectation
	always @(posedge clk) begin
		graph_result_t want;
		if (result_strobe) begin
			if (pending_results.size() == 0) begin
				n_errors++;
				$display({"%0t: unexpected result, expected none actual status %0d",
					" neighbor %0d weight %0d last %0d"},
					$time, status, neighbor, neighbor_weight, last);
			end else begin
				want = pending_results.pop_front();
				n_results++;
				check_field("status", want.status, status);
				check_field("neighbor", want.nb, neighbor);
				check_field("weight", $signed(want.weight), neighbor_weight);
				check_field("last", want.is_last, last);
			end
		end
	end

	// empty table, invalid vertices, add, rewrite, delete and self loop at reset settings
	task automatic test_basic_ops();
		send_item(OP_LIST, 8'd1, 8'd0, 16'sd0);
		send_item(OP_LIST, 8'd0, 8'd1, 16'sd0);
		send_item(OP_LIST, 8'd7, 8'hFF, 16'sh7FFF);
		send_item(OP_MODIFY, 8'd0, 8'd1, 16'sd5);
		send_item(OP_MODIFY, 8'd1, 8'hFF, 16'sd5);
		send_item(OP_MODIFY, 8'd1, 8'd2, 16'sh7FFF);
		send_item(OP_MODIFY, 8'd1, 8'd6, 16'sh8000);
		send_item(OP_MODIFY, 8'd3, 8'd3, 16'sd5);
		send_item(OP_LIST, 8'd1, 8'd0, 16'sd0);
		send_item(OP_MODIFY, 8'd2, 8'd1, 16'shAAAA);
		send_item(OP_LIST, 8'd2, 8'hAA, 16'sh5555);
		send_item(OP_MODIFY, 8'd4, 8'd5, 16'sd0);
		send_item(OP_MODIFY, 8'd6, 8'd1, 16'sd0);
		send_item(OP_LIST, 8'd3, 8'd0, 16'sd0);
		send_item(OP_LIST, 8'd6, 8'd0, 16'sd0);
	endtask

	// additions refused at the limit, also when the limit drops below the count
	task automatic test_edge_limit();
		set_config(6'd6, 6'd2);
		send_item(OP_MODIFY, 8'd4, 8'd5, 16'sd1);
		send_item(OP_LIST, 8'd4, 8'd0, 16'sd0);
		set_config(6'd6, 6'd1);
		send_item(OP_MODIFY, 8'd5, 8'd6, 16'sh5555);
		send_item(OP_MODIFY, 8'd1, 8'd2, 16'sh5555);
		send_item(OP_LIST, 8'd1, 8'd0, 16'sd0);
		set_config(6'd8, 6'd0);
		send_item(OP_MODIFY, 8'd3, 8'd3, 16'sd0);
		send_item(OP_MODIFY, 8'd7, 8'd8, 16'sd1);
		set_config(6'd8, 6'd63);
		send_item(OP_MODIFY, 8'd7, 8'd8, -16'sd1);
		send_item(OP_LIST, 8'd8, 8'd0, 16'sd0);
	endtask

	// zero vertices, count above the table size, and a shrunk range hiding edges
	task automatic test_vertex_count();
		set_config(6'd0, 6'd36);
		send_item(OP_LIST, 8'd1, 8'd0, 16'sd0);
		send_item(OP_MODIFY, 8'd1, 8'd2, 16'sd9);
		set_config(6'h3F, 6'd36);
		send_item(OP_MODIFY, 8'd8, 8'd8, 16'sd77);
		send_item(OP_LIST, 8'd8, 8'd0, 16'sd0);
		send_item(OP_LIST, 8'd9, 8'd0, 16'sd0);
		set_config(6'd1, 6'd36);
		send_item(OP_LIST, 8'd1, 8'd0, 16'sd0);
		send_item(OP_LIST, 8'd2, 8'd0, 16'sd0);
	endtask

	// random transactions over several settings and sender gap rates
	task automatic test_random();
		int gap_modes [3] = '{20, 72, 0};
		for (int m = 0; m < 3; m++) begin
			gap_pct = gap_modes[m];
			for (int p = 0; p < 4; p++) begin
				case (p)
					0: set_config(6'd8, 6'd36);
					1: set_config(CFG_W'($urandom_range(7, 2)), CFG_W'($urandom_range(36)));
					2: set_config(CFG_W'($urandom_range(8, 1)), CFG_W'($urandom_range(10, 3)));
					default: set_config(CFG_W'($urandom_range(15, 9)), 6'd63);
				endcase
				repeat (RANDOM_PER_SETTING) send_random_item();
			end
		end
	endtask

	initial begin
		foreach (shadow_weights[i])
			shadow_weights[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_edge_limit();
		test_vertex_count();
		test_random();
		wait_quiet();

		$display("ran %0d list and %0d modify transactions over %0d register settings",
			n_lists, n_modifies, n_settings);
		$display("checked %0d results, %0d mismatches", n_results, n_errors);
		if (n_errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
